// ===== rtl/core/merkle_proof_verifier_assert.svh =====
// Assertion macros shared by the checker
`ifndef MERKLE_PROOF_VERIFIER_ASSERT_SVH
`define MERKLE_PROOF_VERIFIER_ASSERT_SVH
`define MPV_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MPV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/core/mpv_pkg.sv =====
package mpv_pkg;
	localparam int unsigned WordW = 64;
	localparam int unsigned HashWords = 4;
	localparam int unsigned QDepth = 2;

	typedef logic [WordW-1:0] word_t;
	typedef logic [31:0] w32_t;
	typedef logic [255:0] hash_t;

	typedef enum logic [1:0] {
		REG_ROOT0 = 2'd0,
		REG_ROOT1 = 2'd1,
		REG_ROOT2 = 2'd2,
		REG_ROOT3 = 2'd3
	} reg_idx_t;

	// classified work item passed front to back
	typedef struct packed {
		hash_t sib;
		logic  left;
		logic  leaf;
		logic  last;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BLK1,
		ST_ADD1,
		ST_BLK2,
		ST_ADD2,
		ST_DONE
	} bst_t;

	localparam logic [255:0] InitH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic w32_t round_k(input logic [5:0] t);
		w32_t k;
		case (t)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic w32_t rotr(input w32_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage

// ===== rtl/core/merkle_proof_verifier.sv =====
// Merkle inclusion proof checker using SHA-256.
// Input channel: one proof element per beat (sibling_word0..3, sibling_is_left,
// is_leaf_entry, is_last), accepted when in_valid is high and in_stall is low.
// Output channel: one root_match beat per element marked last, taken when
// out_valid is high and out_stall is low.
// Root hash is set through the APB port, registers at byte addresses 0,8,16,24.
// Steps: a leaf element only loads the running hash; any other element
// runs BLK1, ADD1, BLK2 and ADD2 in turn before DONE, with all rounds done
// by the single round unit.
// A two-entry queue in front lets two elements wait while one is hashed.
// Reset clears the root, running hash, queue pointers and output valid flag.
// While out_stall holds a result, the back end waits in its final step;
// the queue keeps accepting until it is full.
module merkle_proof_verifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] sibling_word0,
	input  logic [63:0] sibling_word1,
	input  logic [63:0] sibling_word2,
	input  logic [63:0] sibling_word3,
	input  logic        sibling_is_left,
	input  logic        is_leaf_entry,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        root_match
);
	import mpv_pkg::*;

	word_t root_q [HashWords];
	job_t  in_job, job;
	logic  job_valid, job_take;
	reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:3]);
	assign prdata = (paddr[2:0] == 3'd0) ? root_q[ridx] : 64'd0;

	// root registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HashWords; i++) root_q[i] <= '0;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			root_q[ridx] <= pwdata;
		end
	end

	assign in_job = '{sib: {sibling_word0, sibling_word1, sibling_word2, sibling_word3},
		left: sibling_is_left, leaf: is_leaf_entry, last: is_last};

	mpv_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_job(in_job), .job_valid(job_valid), .job_take(job_take), .job(job));

	mpv_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_take(job_take),
		.job(job), .root({root_q[REG_ROOT0], root_q[REG_ROOT1], root_q[REG_ROOT2],
		root_q[REG_ROOT3]}), .out_valid(out_valid), .out_stall(out_stall),
		.root_match(root_match));
endmodule

// ===== rtl/core/mpv_front.sv =====
// Front end: accepts packed proof jobs and holds them in a short queue.
module mpv_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  mpv_pkg::job_t  in_job,
	output logic           job_valid,
	input  logic           job_take,
	output mpv_pkg::job_t  job
);
	import mpv_pkg::*;

	job_t       mem_q [QDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall  = (cnt_q == 2'(QDepth));
	assign push      = in_valid && !in_stall;
	assign job_valid = (cnt_q != 2'd0);
	assign job       = mem_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (job_take) rp_q <= ~rp_q;
			case ({push, job_take})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== rtl/core/mpv_back.sv =====
// Back end: one SHA-256 round per cycle, two blocks per non-leaf element.
module mpv_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_take,
	input  mpv_pkg::job_t  job,
	input  mpv_pkg::hash_t root,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           root_match
);
	import mpv_pkg::*;

	bst_t        st_q, st_d;
	job_t        cur_q;
	hash_t       run_q;
	logic [255:0] hsum_q;
	logic [255:0] hnext;
	w32_t        v_q [8];
	w32_t        w_q [16];
	logic [5:0]  rnd_q;
	logic        ov_q, om_q;
	logic [511:0] blk;
	w32_t        wt, wnew, t1, t2, s0, s1, ch, mj, a15, b2;
	logic        load1, load2, rdone, out_free;

	assign out_free  = !ov_q || !out_stall;
	assign out_valid = ov_q;
	assign root_match = om_q;

	// message block for the current block
	always_comb begin
		if (st_q == ST_BLK2) blk = {32'h80000000, 416'd0, 32'd0, 32'd512};
		else if (cur_q.left) blk = {cur_q.sib, run_q};
		else blk = {run_q, cur_q.sib};
	end

	// schedule and round datapath
	always_comb begin
		a15  = w_q[4'(rnd_q - 6'd15)];
		b2   = w_q[4'(rnd_q - 6'd2)];
		wnew = w_q[rnd_q[3:0]] + (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3))
			+ w_q[4'(rnd_q - 6'd7)] + (rotr(b2, 17) ^ rotr(b2, 19) ^ (b2 >> 10));
		wt   = (rnd_q < 6'd16) ? blk[511 - 32*rnd_q[3:0] -: 32] : wnew;
		s1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + s1 + ch + round_k(rnd_q) + wt;
		s0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = s0 + mj;
	end

	// chaining value after a block: running sum plus working vars
	always_comb begin
		for (int i = 0; i < 8; i++)
			hnext[255 - 32*i -: 32] = hsum_q[255 - 32*i -: 32] + v_q[i];
	end

	assign rdone = (rnd_q == 6'd63);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (job_valid) st_d = job.leaf ? ST_DONE : ST_BLK1;
			ST_BLK1: if (rdone) st_d = ST_ADD1;
			ST_ADD1: st_d = ST_BLK2;
			ST_BLK2: if (rdone) st_d = ST_ADD2;
			ST_ADD2: st_d = ST_DONE;
			ST_DONE: if (!cur_q.last || out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		job_take = (st_q == ST_IDLE) && job_valid;
		load1    = job_take && !job.leaf;
		load2    = (st_q == ST_ADD1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; rnd_q <= 6'd0; ov_q <= 1'b0; run_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_BLK1 || st_q == ST_BLK2) rnd_q <= rnd_q + 6'd1;
			if (job_take && job.leaf) run_q <= job.sib;
			else if (st_q == ST_ADD2) run_q <= hnext;
			if (st_q == ST_DONE && cur_q.last && out_free) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (job_take) cur_q <= job;
		if (st_q == ST_DONE && cur_q.last && out_free) om_q <= (run_q == root);
		if (load1) hsum_q <= InitH;
		else if (load2) hsum_q <= hnext;
		if (load1 || load2) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= load1 ? InitH[255 - 32*i -: 32] : hnext[255 - 32*i -: 32];
		end else if (st_q == ST_BLK1 || st_q == ST_BLK2) begin
			w_q[rnd_q[3:0]] <= wt;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1; v_q[3] <= v_q[2]; v_q[2] <= v_q[1];
			v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
		end
	end
endmodule

// ===== rtl/core/mpv_checker.sv =====
// Port-level checks on the verifier
module mpv_checker (
	input logic clk,
	input logic arst_n,
	input logic pready,
	input logic out_valid,
	input logic out_stall,
	input logic root_match
);
`include "merkle_proof_verifier_assert.svh"
	`MPV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(root_match), "result dropped while stalled")
	`MPV_ASSERT_IMPL(a_pready_high, 1'b1, pready, "pready low")
	`MPV_ASSERT_IMPL(a_rst_quiet, $rose(arst_n), !out_valid, "output valid out of reset")
endmodule

bind merkle_proof_verifier mpv_checker u_mpv_checker (
	.clk(clk), .arst_n(arst_n), .pready(pready),
	.out_valid(out_valid), .out_stall(out_stall),
	.root_match(root_match));
